// ----- src/grmr_pkg.sv -----
// Package: shared constants, types and arithmetic helpers for the running mean/rms block
package grmr_pkg;

  localparam int NumSlots = 16;
  localparam int SlotBits = 4;
  localparam int CountBits = 16;
  localparam logic [CountBits-1:0] CntMax = '1;

  // Request codes
  localparam logic ReqSample = 1'b0;
  localparam logic ReqRead = 1'b1;

  // Running accumulator entry
  typedef struct packed {
    logic signed [31:0] mean;
    logic [63:0] var_acc;
    logic [CountBits-1:0] count;
    logic [63:0] data_time;
    logic [63:0] init_time;
  } run_entry_t;

  // Latched result and per-slot bookkeeping
  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0] rms;
    logic [CountBits-1:0] count;
    logic [63:0] time_stamp;
    logic [31:0] repeats;
    logic [31:0] overruns;
    logic read_pend;
    logic restart_pend;
  } held_entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EVAL, S_DIV_MEAN, S_DIV_KEEP, S_DIV_ADD, S_SUM,
    S_DONE_DIV, S_SQRT, S_WRITE, S_OUT
  } state_t;

  // Divider request/response
  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [CountBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic [63:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] c);
    sat_inc32 = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

// ----- src/grmr_div.sv -----
// Restoring divider: 64-bit dividend by count-width divisor, one quotient bit per cycle
module grmr_div
  import grmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] quo;
  logic [CountBits:0] rem;
  logic [CountBits-1:0] dvs;
  logic [6:0] steps;
  logic busy;
  logic [CountBits:0] trial;
  logic [CountBits:0] shifted;

  // Shift in the next dividend bit and test
  always_comb begin
    shifted = {rem[CountBits-1:0], quo[63]};
    trial = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      steps <= 7'd64;
    end else if (busy) begin
      steps <= steps - 7'd1;
      if (steps == 7'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[CountBits]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.quotient = quo;

endmodule

// ----- src/gated_running_mean_rms.sv -----
// Top level: per-slot gated running mean and rms with memory-held state
// Usage:
//   Input channel (in_valid/in_stall) carries one request beat: a sample for
//   a slot, or a read of the slot's latched result. Each beat yields exactly
//   one result beat on the output channel (out_valid/out_stall).
//   Configuration channel (cfg_valid/cfg_ready) writes no_average; write it
//   only while the block is idle.
// Sequence after the accepting edge:
//   Read, skipped or rejected sample: fetch, evaluate, write back, output.
//   Window end without an averaging step: one divide, then the square root.
//   Averaging step: three divides (mean step, variance keep term, variance
//   add term); at window end a fourth divide and the square root follow.
// Flow: one item in flight; the next beat is taken the cycle after the
//   result beat leaves.
// Reset:
//   rst is synchronous. Slot state sits in two 16-entry memories; a valid bit
//   per slot makes an unwritten slot read as all zero, so no clearing pass.
// Stall:
//   The result sits in an output register; while out_stall is high the block
//   holds it and accepts no new beat.
module gated_running_mean_rms
  import grmr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic no_average,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [3:0] slot_index,
  input  logic [63:0] sample_time,
  input  logic signed [31:0] sample_value,
  input  logic [3:0] sample_severity,
  input  logic [63:0] slot_time,
  input  logic [63:0] slot_init_time,
  input  logic slot_avg_done,
  input  logic [3:0] slot_severity_limit,
  input  logic slot_status_ok,
  output logic out_valid,
  input  logic out_stall,
  output logic result_valid,
  output logic signed [31:0] mean_out,
  output logic [31:0] rms_out,
  output logic [15:0] count_out,
  output logic [63:0] data_time_out,
  output logic [31:0] nochange_count,
  output logic [31:0] noread_count,
  output logic reset_request,
  output logic error_flag
);

  // Memories and valid bits
  run_entry_t run_mem [NumSlots];
  held_entry_t held_mem [NumSlots];
  logic [NumSlots-1:0] run_vld, held_vld;
  run_entry_t run_rd_raw, run_cur;
  held_entry_t held_rd_raw, held_cur;
  logic run_rd_vld, held_rd_vld;
  logic mem_we;

  // Item registers
  logic cfg_noavg;
  logic it_req;
  logic [SlotBits-1:0] it_slot;
  logic [63:0] it_stime, it_slot_time, it_init;
  logic signed [31:0] it_x;
  logic [3:0] it_sev, it_limit;
  logic it_done, it_ok;

  // Working registers
  run_entry_t run_w;
  held_entry_t held_w;
  logic [31:0] ad_reg;
  logic [63:0] sq_reg, keep_reg, add_reg;
  logic [CountBits-1:0] n_reg;
  logic d_neg;
  logic rd_pend_q, restart_q;

  // Square root unit state
  logic [63:0] sq_v, sq_r, sq_bit;

  state_t state, state_next;
  div_req_t dreq;
  div_rsp_t drsp;
  logic dbusy_d, div_fin;

  // Evaluation of the fetched entry
  run_entry_t r0;
  held_entry_t h0;
  logic samp_go, win_end, upd, rv;
  logic [CountBits-1:0] n_first;
  logic signed [32:0] d_e;
  logic [32:0] ad_e;
  logic [31:0] q_lo;
  logic [64:0] sum_wide;
  logic [63:0] var_sum;

  // Output register
  logic o_vld, o_rv, o_rst, o_err;
  logic signed [31:0] o_mean;
  logic [31:0] o_rms, o_rep, o_ovr;
  logic [15:0] o_cnt;
  logic [63:0] o_time;

  grmr_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || o_vld;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) cfg_noavg <= 1'b0;
    else if (cfg_valid && cfg_ready) cfg_noavg <= no_average;
  end

  // Item capture on the accepting edge
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) begin
      it_req <= req_type;
      it_slot <= slot_index;
      it_stime <= sample_time;
      it_x <= sample_value;
      it_sev <= sample_severity;
      it_slot_time <= slot_time;
      it_init <= slot_init_time;
      it_done <= slot_avg_done;
      it_limit <= slot_severity_limit;
      it_ok <= slot_status_ok;
    end
  end

  // Memory read, registered
  always_ff @(posedge clk) begin
    run_rd_raw <= run_mem[it_slot];
    held_rd_raw <= held_mem[it_slot];
    run_rd_vld <= run_vld[it_slot];
    held_rd_vld <= held_vld[it_slot];
  end
  assign run_cur = run_rd_vld ? run_rd_raw : '0;
  assign held_cur = held_rd_vld ? held_rd_raw : '0;

  // Memory write back
  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_mem[it_slot] <= run_w;
      held_mem[it_slot] <= held_w;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      run_vld <= '0;
      held_vld <= '0;
    end else if (mem_we) begin
      run_vld[it_slot] <= 1'b1;
      held_vld[it_slot] <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
  always_ff @(posedge clk) begin
    if (rst) dbusy_d <= 1'b0;
    else dbusy_d <= drsp.busy;
  end
  assign div_fin = dbusy_d && !drsp.busy;

  // Init, repeat and first-sample rules on the fetched entry
  always_comb begin
    r0 = run_cur;
    h0 = held_cur;
    samp_go = (it_req == ReqSample) && it_ok && (it_stime == it_slot_time);
    win_end = samp_go && it_done;
    upd = 1'b0;
    n_first = '0;
    if (it_req == ReqRead) begin
      h0.read_pend = 1'b0;
      h0.restart_pend = 1'b0;
    end else if (samp_go) begin
      if (it_init != run_cur.init_time) begin
        r0.init_time = it_init;
        r0.mean = '0;
        r0.var_acc = '0;
        r0.count = '0;
        if (h0.read_pend) h0.overruns = sat_inc32(h0.overruns);
        h0.read_pend = 1'b0;
        h0.restart_pend = 1'b1;
      end
      if (it_stime == r0.data_time) begin
        h0.repeats = sat_inc32(h0.repeats);
      end else begin
        r0.data_time = it_stime;
        if (it_sev < it_limit) begin
          n_first = (r0.count == CntMax) ? r0.count : r0.count + CountBits'(1);
          if (n_first == CountBits'(1) || cfg_noavg) begin
            r0.count = CountBits'(1);
            r0.mean = it_x;
            r0.var_acc = '0;
          end else begin
            r0.count = n_first;
            upd = 1'b1;
          end
        end
      end
    end
  end

  // Deviation from the mean, sign and magnitude
  always_comb begin
    d_e = 33'(it_x) - 33'(r0.mean);
    ad_e = $unsigned(d_e[32] ? -d_e : d_e);
  end

  // Saturating variance sum and low quotient
  always_comb begin
    sum_wide = {1'b0, keep_reg} + {1'b0, add_reg};
    var_sum = sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
    q_lo = drsp.quotient[31:0];
  end

  // Next state and divider requests
  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    dreq = '0;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) state_next = S_READ;
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (upd) begin
          dreq.start = 1'b1;
          dreq.dividend = {31'd0, ad_e};
          dreq.divisor = r0.count;
          state_next = S_DIV_MEAN;
        end else if (win_end) begin
          dreq.start = 1'b1;
          dreq.dividend = r0.var_acc;
          dreq.divisor = (r0.count == '0) ? CountBits'(1) : r0.count;
          state_next = S_DONE_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV_MEAN: if (div_fin) begin
        dreq.start = 1'b1;
        dreq.dividend = run_w.var_acc;
        dreq.divisor = n_reg - CountBits'(1);
        state_next = S_DIV_KEEP;
      end
      S_DIV_KEEP: if (div_fin) begin
        dreq.start = 1'b1;
        dreq.dividend = sq_reg;
        dreq.divisor = n_reg;
        state_next = S_DIV_ADD;
      end
      S_DIV_ADD: if (div_fin) state_next = S_SUM;
      S_SUM: begin
        if (it_done) begin
          dreq.start = 1'b1;
          dreq.dividend = var_sum;
          dreq.divisor = n_reg;
          state_next = S_DONE_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DONE_DIV: if (div_fin) state_next = S_SQRT;
      S_SQRT: if (sq_bit == '0) state_next = S_WRITE;
      S_WRITE: begin
        mem_we = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Working entry: load, mean step, variance terms, window end latch
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      run_w <= r0;
      held_w <= h0;
      n_reg <= r0.count;
      d_neg <= d_e[32];
      ad_reg <= ad_e[31:0];
      rd_pend_q <= held_cur.read_pend;
      restart_q <= held_cur.restart_pend;
    end
    if (state == S_DIV_MEAN) sq_reg <= 64'(ad_reg) * 64'(ad_reg);
    if (state == S_DIV_MEAN && div_fin) begin
      // truncate toward zero: apply the sign to the magnitude quotient
      run_w.mean <= run_w.mean + (d_neg ? (32'd0 - q_lo) : q_lo);
    end
    if (state == S_DIV_KEEP && div_fin) keep_reg <= run_w.var_acc - drsp.quotient;
    if (state == S_DIV_ADD && div_fin) add_reg <= drsp.quotient;
    if (state == S_SUM) run_w.var_acc <= var_sum;
    if (state == S_SQRT && sq_bit == '0) begin
      held_w.mean <= run_w.mean;
      held_w.count <= run_w.count;
      held_w.time_stamp <= run_w.data_time;
      held_w.rms <= (run_w.count <= CountBits'(1)) ? 32'd0 : sq_r[31:0];
      run_w.count <= '0;
      run_w.mean <= '0;
      if (held_w.read_pend) held_w.overruns <= sat_inc32(held_w.overruns);
      else held_w.read_pend <= 1'b1;
    end
  end

  // Square root: start on divider finish, one result bit per cycle
  always_ff @(posedge clk) begin
    if (state == S_DONE_DIV && div_fin) begin
      sq_v <= drsp.quotient;
      sq_r <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
    end else if (state == S_SQRT && sq_bit != '0) begin
      if (sq_v >= sq_r + sq_bit) begin
        sq_v <= sq_v - (sq_r + sq_bit);
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (state == S_OUT) begin
      o_vld <= 1'b1;
    end else if (o_vld && !out_stall) begin
      o_vld <= 1'b0;
    end
  end

  assign rv = (it_req == ReqRead) ? rd_pend_q : win_end;

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      o_rv <= rv;
      o_mean <= rv ? held_w.mean : '0;
      o_rms <= rv ? held_w.rms : '0;
      o_cnt <= rv ? held_w.count : '0;
      o_time <= rv ? held_w.time_stamp : '0;
      o_rep <= held_w.repeats;
      o_ovr <= held_w.overruns;
      o_rst <= (it_req == ReqRead) && restart_q;
      o_err <= (it_req == ReqSample) && !it_ok;
    end
  end

  assign out_valid = o_vld;
  assign result_valid = o_rv;
  assign mean_out = o_mean;
  assign rms_out = o_rms;
  assign count_out = o_cnt;
  assign data_time_out = o_time;
  assign nochange_count = o_rep;
  assign noread_count = o_ovr;
  assign reset_request = o_rst;
  assign error_flag = o_err;

  // Checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (o_vld && out_stall) |=> o_vld) else $error("result dropped under stall");
  a_we_once: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !mem_we) else $error("double write-back");

endmodule

// ----- test/gated_running_mean_rms_tb.sv -----
// Testbench for gated_running_mean_rms: per-slot running mean/rms checked against a predictor
module gated_running_mean_rms_tb
  import grmr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One result beat as seen on the output ports
  typedef struct {
    logic rv;
    logic [31:0] mean;
    logic [31:0] rms;
    logic [15:0] cnt;
    logic [63:0] dtime;
    logic [31:0] nochg;
    logic [31:0] noread;
    logic rreq;
    logic err;
  } stat_beat_t;

  // One request beat
  typedef struct {
    logic req;
    logic [3:0] slot;
    logic [63:0] stime;
    logic [31:0] val;
    logic [3:0] sev;
    logic [63:0] ltime;
    logic [63:0] itime;
    logic done;
    logic [3:0] lim;
    logic ok;
  } req_beat_t;

  // Scoreboard: slot accumulator model plus queue of pending result beats
  class stat_scoreboard;
    logic avg_off;
    logic signed [63:0] mean_acc [NumSlots];
    logic [63:0] var_acc [NumSlots];
    logic [63:0] cnt_acc [NumSlots];
    logic [63:0] last_t [NumSlots];
    logic [63:0] init_t [NumSlots];
    logic signed [63:0] h_mean [NumSlots];
    logic [63:0] h_rms [NumSlots];
    logic [63:0] h_cnt [NumSlots];
    logic [63:0] h_time [NumSlots];
    logic [31:0] repeats [NumSlots];
    logic [31:0] overruns [NumSlots];
    logic rd_pend [NumSlots];
    logic rst_pend [NumSlots];
    stat_beat_t pending_stats[$];
    int errors;

    function void clear();
      avg_off = 0;
      errors = 0;
      for (int i = 0; i < NumSlots; i++) begin
        mean_acc[i] = 0; var_acc[i] = 0; cnt_acc[i] = 0; last_t[i] = 0;
        init_t[i] = 0; h_mean[i] = 0; h_rms[i] = 0; h_cnt[i] = 0;
        h_time[i] = 0; repeats[i] = 0; overruns[i] = 0;
        rd_pend[i] = 0; rst_pend[i] = 0;
      end
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 1;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void fold_sample(int s, logic signed [63:0] x);
      logic [63:0] n, ad, keep, add, sum;
      logic signed [63:0] d;
      n = cnt_acc[s];
      if (n < 64'(CntMax)) n++;
      cnt_acc[s] = n;
      if (n == 1 || avg_off) begin
        cnt_acc[s] = 1;
        mean_acc[s] = x;
        var_acc[s] = 0;
      end else begin
        d = x - mean_acc[s];
        ad = (d < 0) ? -d : d;
        mean_acc[s] = mean_acc[s] + d / $signed(n);
        ad = ad * ad;
        keep = var_acc[s] - var_acc[s] / (n - 1);
        add = ad / n;
        sum = keep + add;
        var_acc[s] = (sum < keep) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
      end
    endfunction

    function stat_beat_t make_beat(logic v, int s, logic rr, logic e);
      stat_beat_t b;
      b.rv = v;
      b.mean = v ? h_mean[s][31:0] : 0;
      b.rms = v ? h_rms[s][31:0] : 0;
      b.cnt = v ? h_cnt[s][15:0] : 0;
      b.dtime = v ? h_time[s] : 0;
      b.nochg = repeats[s];
      b.noread = overruns[s];
      b.rreq = rr;
      b.err = e;
      return b;
    endfunction

    // Note an accepted request beat and queue its expected result
    function void note_request(req_beat_t r);
      int s;
      logic v, rr;
      logic [63:0] n;
      s = r.slot;
      if (r.req == ReqRead) begin
        v = rd_pend[s];
        rr = rst_pend[s];
        rd_pend[s] = 0;
        rst_pend[s] = 0;
        pending_stats.push_back(make_beat(v, s, rr, 0));
        return;
      end
      if (!r.ok) begin
        pending_stats.push_back(make_beat(0, s, 0, 1));
        return;
      end
      if (r.stime != r.ltime) begin
        pending_stats.push_back(make_beat(0, s, 0, 0));
        return;
      end
      // init time change restarts the slot
      if (r.itime != init_t[s]) begin
        init_t[s] = r.itime;
        mean_acc[s] = 0; var_acc[s] = 0; cnt_acc[s] = 0;
        if (rd_pend[s]) overruns[s] = bump(overruns[s]);
        rd_pend[s] = 0;
        rst_pend[s] = 1;
      end
      if (r.stime == last_t[s]) begin
        repeats[s] = bump(repeats[s]);
      end else begin
        last_t[s] = r.stime;
        if (r.sev < r.lim) fold_sample(s, 64'($signed(r.val)));
      end
      // window end latches the result
      if (r.done) begin
        n = cnt_acc[s];
        h_mean[s] = mean_acc[s];
        h_cnt[s] = n;
        h_time[s] = last_t[s];
        h_rms[s] = (n <= 1) ? 0 : int_sqrt(var_acc[s] / n);
        cnt_acc[s] = 0;
        mean_acc[s] = 0;
        if (rd_pend[s]) overruns[s] = bump(overruns[s]);
        else rd_pend[s] = 1;
      end
      pending_stats.push_back(make_beat(r.done, s, 0, 0));
    endfunction

    function void check_field(string nm, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %h actual %h", $time, nm, e, a);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(stat_beat_t a);
      stat_beat_t e;
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual rv=%b", $time, a.rv);
        errors++;
        return;
      end
      e = pending_stats.pop_front();
      check_field("result_valid", e.rv, a.rv);
      check_field("mean_out", e.mean, a.mean);
      check_field("rms_out", e.rms, a.rms);
      check_field("count_out", e.cnt, a.cnt);
      check_field("data_time_out", e.dtime, a.dtime);
      check_field("nochange_count", e.nochg, a.nochg);
      check_field("noread_count", e.noread, a.noread);
      check_field("reset_request", e.rreq, a.rreq);
      check_field("error_flag", e.err, a.err);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready, no_average = 0;
  logic in_valid = 0, in_stall;
  logic req_type = 0;
  logic [3:0] slot_index = 0;
  logic [63:0] sample_time = 0;
  logic signed [31:0] sample_value = 0;
  logic [3:0] sample_severity = 0;
  logic [63:0] slot_time = 0, slot_init_time = 0;
  logic slot_avg_done = 0;
  logic [3:0] slot_severity_limit = 0;
  logic slot_status_ok = 0;
  logic out_valid, out_stall = 1;
  logic result_valid, reset_request, error_flag;
  logic signed [31:0] mean_out;
  logic [31:0] rms_out, nochange_count, noread_count;
  logic [15:0] count_out;
  logic [63:0] data_time_out;

  stat_scoreboard sb;
  int cycles = 0;
  bit no_gaps = 0;
  int hold_off = 0;
  int sent = 0;
  logic [63:0] slot_clock [NumSlots];
  logic [63:0] slot_epoch [NumSlots];

  gated_running_mean_rms DUT (.*);

  always #5 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result sampling
  always @(posedge clk) begin
    stat_beat_t b;
    if (!rst && out_valid && !out_stall) begin
      b.rv = result_valid; b.mean = mean_out; b.rms = rms_out; b.cnt = count_out;
      b.dtime = data_time_out; b.nochg = nochange_count; b.noread = noread_count;
      b.rreq = reset_request; b.err = error_flag;
      sb.check_result(b);
    end
  end

  // Receiver stall: random, or a long hold-off when requested
  always @(negedge clk) begin
    if (rst) out_stall <= 1;
    else if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else out_stall <= !no_gaps && ($urandom_range(99) < 6);
  end

  // Drive one request beat and wait for acceptance; valid stays up afterwards
  task automatic send(req_beat_t r);
    while (!no_gaps && $urandom_range(99) < 6) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; req_type <= r.req; slot_index <= r.slot;
    sample_time <= r.stime; sample_value <= r.val; sample_severity <= r.sev;
    slot_time <= r.ltime; slot_init_time <= r.itime; slot_avg_done <= r.done;
    slot_severity_limit <= r.lim; slot_status_ok <= r.ok;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_mode(logic v);
    in_valid <= 0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1;
    no_average <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.avg_off = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Well-formed sample for a slot, with random content and occasional faults
  function automatic req_beat_t sample_beat(int s, bit done);
    req_beat_t r;
    int p;
    p = $urandom_range(99);
    if (p > 3) slot_clock[s] = slot_clock[s] + $urandom_range(1, 1000);
    if (p == 0) slot_epoch[s] = {$urandom, $urandom};
    r.req = ReqSample; r.slot = 4'(s); r.stime = slot_clock[s];
    r.ltime = (p == 1) ? slot_clock[s] ^ (64'd1 << $urandom_range(63)) : slot_clock[s];
    r.val = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(4000)) - 2000;
    r.sev = 4'($urandom_range(15));
    r.lim = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd15;
    r.itime = slot_epoch[s]; r.done = done; r.ok = (p != 2);
    return r;
  endfunction

  function automatic req_beat_t read_beat(int s);
    req_beat_t r;
    r = '{default: 0};
    r.req = ReqRead; r.slot = 4'(s);
    r.stime = {$urandom, $urandom}; r.val = $urandom; r.done = 1'($urandom);
    return r;
  endfunction

  initial begin
    req_beat_t r;
    sb = new();
    sb.clear();
    for (int i = 0; i < NumSlots; i++) begin
      slot_clock[i] = 100; slot_epoch[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, restart, repeat, bad status, mismatch, reads
    write_mode(0);
    r = '{req: ReqSample, slot: 0, stime: 64'hFFFF_FFFF_FFFF_FFFF, val: 32'h7FFF_FFFF,
          sev: 0, ltime: 64'hFFFF_FFFF_FFFF_FFFF, itime: 64'hFFFF_FFFF_FFFF_FFFF,
          done: 0, lim: 15, ok: 1};
    send(r);
    r.stime = 0; r.ltime = 0; r.val = 32'h8000_0000; send(r);
    r.stime = 5; r.ltime = 5; r.val = 32'h7FFF_FFFF; send(r);
    r.done = 1; send(r);                        // repeated time, window end
    send(read_beat(0)); send(read_beat(0));
    r.done = 0; r.stime = 6; r.ltime = 6; r.sev = 15; r.lim = 0; send(r);  // severity reject
    r.ok = 0; send(r);                          // bad status
    r.ok = 1; r.ltime = 7; send(r);             // time mismatch
    r.ltime = 8; r.stime = 8; r.lim = 15; r.sev = 3; r.done = 1; send(r);
    r.stime = 9; r.ltime = 9; send(r);          // overrun
    r.itime = 1; r.stime = 10; r.ltime = 10; send(r);  // restart with pending latch
    send(read_beat(0)); send(read_beat(15));
    r.slot = 15; r.itime = 0; r.done = 0; send(r);
    write_mode(1);
    r.stime = 11; r.ltime = 11; send(r);
    r.stime = 12; r.ltime = 12; r.val = 32'h8000_0000; r.done = 1; send(r);
    send(read_beat(15));

    // Random: windows of samples per slot, reads, mode changes
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      if (ph == 2) begin
        no_gaps = 1;
        hold_off = 300;
      end
      for (int k = 0; k < 135; k++) begin
        int s;
        s = $urandom_range(ph == 3 ? 15 : 3);
        if ($urandom_range(9) < 2) send(read_beat(s));
        else send(sample_beat(s, $urandom_range(9) == 0));
      end
      no_gaps = 0;
    end

    in_valid <= 0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending_stats.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
